@@ sv/c2d_pkg.sv @@
`default_nettype none
package c2d_pkg;
	typedef enum logic [1:0] {
		REQ_WEIGHT  = 2'd0,
		REQ_PIXEL   = 2'd1,
		REQ_COMPUTE = 2'd2,
		REQ_NONE    = 2'd3
	} req_e_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EVEN     = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;

	localparam logic [2:0] CFG_IMG_ROWS = 3'd0;
	localparam logic [2:0] CFG_IMG_COLS = 3'd1;
	localparam logic [2:0] CFG_KER_ROWS = 3'd2;
	localparam logic [2:0] CFG_KER_COLS = 3'd3;
	localparam logic [2:0] CFG_VALID    = 3'd4;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [5:0]         row;
		logic [5:0]         col;
		logic signed [31:0] value;
	} in_beat_t;

	typedef struct packed {
		logic signed [31:0] sum_value;
		logic [1:0]         status;
	} out_beat_t;

	// controller -> datapath
	typedef struct packed {
		logic start;   // latch window bounds from request
		logic step;    // issue read for current tap, advance
		logic acc;     // accumulate product stage
		logic clr;     // clear accumulator
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last_tap;  // current tap is the final one
		logic empty;     // window has no taps
	} dp_sts_t;
endpackage
`default_nettype wire

@@ sv/c2d_datapath.sv @@
`default_nettype none
module c2d_datapath import c2d_pkg::*; #(
	parameter int MAX_ROWS   = 64,
	parameter int MAX_COLS   = 64,
	parameter int MAX_KERNEL = 7,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire in_beat_t    in_beat,
	input  wire logic        wr_en,
	input  wire dp_cmd_t     cmd,
	input  wire logic [6:0]  nr,
	input  wire logic [6:0]  nc,
	input  wire logic [2:0]  kr,
	input  wire logic [2:0]  kc,
	input  wire logic        vmode,
	output dp_sts_t          sts,
	output logic [31:0]      sum
);
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int KW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int KD = MAX_KERNEL * MAX_KERNEL;
	localparam int ID = MAX_ROWS * MAX_COLS;
	localparam int KAW = (KD > 1) ? $clog2(KD) : 1;
	localparam int IAW = (ID > 1) ? $clog2(ID) : 1;

	logic [31:0] img_mem [ID];
	logic [31:0] ker_mem [KD];

	// image write address via row*MAX_COLS+col, kernel likewise
	logic [IAW-1:0] img_wa, img_ra;
	logic [KAW-1:0] ker_wa, ker_ra;
	logic img_we, ker_we;

	always_comb begin
		img_we = wr_en && in_beat.req_type == REQ_PIXEL
			&& 32'(in_beat.row) < 32'(MAX_ROWS) && 32'(in_beat.col) < 32'(MAX_COLS);
		ker_we = wr_en && in_beat.req_type == REQ_WEIGHT
			&& 32'(in_beat.row) < 32'(MAX_KERNEL) && 32'(in_beat.col) < 32'(MAX_KERNEL);
		img_wa = IAW'(32'(in_beat.row) * MAX_COLS + 32'(in_beat.col));
		ker_wa = KAW'(32'(in_beat.row) * MAX_KERNEL + 32'(in_beat.col));
	end

	// window bounds (image coords); 8 bits covers up to 63+3+3+1
	logic [7:0] m_q, n_q, n0_q, m1_q, n1_q;
	logic [7:0] off_r_q, off_c_q; // kernel index = image index + cx - ci
	logic [7:0] ci, cj, cx, cy, m0, m1, n0, n1;

	always_comb begin
		cx = 8'(kr >> 1);
		cy = 8'(kc >> 1);
		ci = vmode ? 8'(in_beat.row) + cx : 8'(in_beat.row);
		cj = vmode ? 8'(in_beat.col) + cy : 8'(in_beat.col);
		m0 = ci >= cx ? ci - cx : 8'd0;
		n0 = cj >= cy ? cj - cy : 8'd0;
		m1 = (ci + cx + 8'd1) < 8'(nr) ? ci + cx + 8'd1 : 8'(nr);
		n1 = (cj + cy + 8'd1) < 8'(nc) ? cj + cy + 8'd1 : 8'(nc);
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			m_q     <= m0;
			n_q     <= n0;
			n0_q    <= n0;
			m1_q    <= m1;
			n1_q    <= n1;
			off_r_q <= cx - ci;
			off_c_q <= cy - cj;
		end else if (cmd.step) begin
			if (n_q + 8'd1 >= n1_q) begin
				n_q <= n0_q;
				m_q <= m_q + 8'd1;
			end else begin
				n_q <= n_q + 8'd1;
			end
		end
	end

	assign sts.empty    = (m_q >= m1_q) || (n0_q >= n1_q);
	assign sts.last_tap = (m_q + 8'd1 >= m1_q) && (n_q + 8'd1 >= n1_q);

	logic [7:0] kx, ky;
	always_comb begin
		kx = m_q + off_r_q;
		ky = n_q + off_c_q;
		img_ra = IAW'(32'(m_q[RW-1:0]) * MAX_COLS + 32'(n_q[CW-1:0]));
		ker_ra = KAW'(32'(kx[KW-1:0]) * MAX_KERNEL + 32'(ky[KW-1:0]));
	end

	logic [31:0] w_s1, x_s1;
	logic        v_s1, v_s2;
	logic signed [63:0] p_s2;

	always_ff @(posedge clk) begin
		if (img_we) img_mem[img_wa] <= in_beat.value;
		if (ker_we) ker_mem[ker_wa] <= in_beat.value;
		x_s1 <= img_mem[img_ra];
		w_s1 <= ker_mem[ker_ra];
		p_s2 <= $signed(w_s1) * $signed(x_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			sum  <= '0;
		end else begin
			v_s1 <= cmd.step;
			v_s2 <= v_s1;
			if (cmd.clr) sum <= '0;
			else if (v_s2 && cmd.acc) sum <= sum + 32'(p_s2 >>> FRAC_BITS);
		end
	end
endmodule
`default_nettype wire

@@ sv/c2d_ctrl.sv @@
`default_nettype none
module c2d_ctrl import c2d_pkg::*; #(
	parameter int MAX_ROWS   = 64,
	parameter int MAX_COLS   = 64,
	parameter int MAX_KERNEL = 7
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire in_beat_t    in_beat,
	output logic             out_valid,
	input  wire logic        out_stall,
	output out_beat_t        out_beat,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [6:0]  cfg_data,
	output logic [6:0]       nr,
	output logic [6:0]       nc,
	output logic [2:0]       kr,
	output logic [2:0]       kc,
	output logic             vmode,
	output logic             wr_en,
	output dp_cmd_t          cmd,
	input  wire dp_sts_t     sts,
	input  wire logic [31:0] sum
);
	typedef enum logic [2:0] {S_IDLE, S_SETUP, S_RUN, S_DRAIN1, S_DRAIN2, S_OUT} state_t;
	state_t state_q;
	logic [6:0] img_rows_q, img_cols_q;
	logic [2:0] ker_rows_q, ker_cols_q;
	logic       vmode_q;

	always_comb begin
		nr = 32'(img_rows_q) > MAX_ROWS ? 7'(MAX_ROWS) : img_rows_q;
		nc = 32'(img_cols_q) > MAX_COLS ? 7'(MAX_COLS) : img_cols_q;
		kr = 32'(ker_rows_q) > MAX_KERNEL ? 3'(MAX_KERNEL) : ker_rows_q;
		kc = 32'(ker_cols_q) > MAX_KERNEL ? 3'(MAX_KERNEL) : ker_cols_q;
		vmode = vmode_q;
	end

	logic [6:0] gr, gc;
	logic       even, oor;
	always_comb begin
		gr = vmode_q ? (nr >= 7'(kr) ? nr - 7'(kr) + 7'd1 : 7'd0) : nr;
		gc = vmode_q ? (nc >= 7'(kc) ? nc - 7'(kc) + 7'd1 : 7'd0) : nc;
		even = !kr[0] || !kc[0];
		oor  = 7'(in_beat.row) >= gr || 7'(in_beat.col) >= gc;
	end

	logic accept;
	assign in_stall = state_q != S_IDLE || out_valid;
	assign accept   = in_valid && !in_stall;
	assign wr_en    = accept;

	always_comb begin
		cmd = '0;
		cmd.start = accept && in_beat.req_type == REQ_COMPUTE;
		cmd.clr   = cmd.start;
		cmd.step  = state_q == S_RUN;
		cmd.acc   = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			out_valid  <= 1'b0;
			out_beat   <= '0;
			img_rows_q <= 7'd64;
			img_cols_q <= 7'd64;
			ker_rows_q <= 3'd3;
			ker_cols_q <= 3'd3;
			vmode_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_IMG_ROWS: img_rows_q <= cfg_data;
					CFG_IMG_COLS: img_cols_q <= cfg_data;
					CFG_KER_ROWS: ker_rows_q <= cfg_data[2:0];
					CFG_KER_COLS: ker_cols_q <= cfg_data[2:0];
					CFG_VALID:    vmode_q    <= cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						if (even) begin
							out_valid <= 1'b1;
							out_beat  <= '{sum_value: '0, status: ST_EVEN};
						end else if (oor) begin
							out_valid <= 1'b1;
							out_beat  <= '{sum_value: '0, status: ST_RANGE};
						end else begin
							state_q <= S_SETUP;
						end
					end
				end
				S_SETUP: state_q <= sts.empty ? S_OUT : S_RUN;
				// hold in run until the final tap issues
				S_RUN:    if (sts.last_tap) state_q <= S_DRAIN1;
				S_DRAIN1: state_q <= S_DRAIN2;
				S_DRAIN2: state_q <= S_OUT;
				S_OUT: begin
					out_valid <= 1'b1;
					out_beat  <= '{sum_value: sum, status: ST_OK};
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ sv/conv2d_fixed_point_same_valid_unit.sv @@
`default_nettype none
// Fixed-point 2D convolution with on-chip image and kernel stores. Weight and
// pixel writes give no beat. A compute passes a setup state, then issues one
// kernel tap per cycle through a single multiply-accumulate (up to 49 for a
// 7x7 kernel, fewer at image borders), then drains the memory read, multiply
// and result stages; even kernels and out-of-grid positions answer in the
// cycle after the request. One request is in flight at a time, and a new one is
// taken only after the previous result beat has left.
module conv2d_fixed_point_same_valid_unit import c2d_pkg::*; #(
	parameter int MAX_ROWS   = 64,
	parameter int MAX_COLS   = 64,
	parameter int MAX_KERNEL = 7,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire in_beat_t   in_data,
	output logic            out_valid,
	input  wire logic       out_stall,
	output out_beat_t       out_data,
	input  wire logic       cfg_we,
	input  wire logic [2:0] cfg_idx,
	input  wire logic [6:0] cfg_data
);
	logic [6:0] nr, nc;
	logic [2:0] kr, kc;
	logic       vmode, wr_en;
	dp_cmd_t    cmd;
	dp_sts_t    sts;
	logic [31:0] sum;

	c2d_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_KERNEL(MAX_KERNEL)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .in_beat(in_data),
		.out_valid, .out_stall, .out_beat(out_data),
		.cfg_we, .cfg_idx, .cfg_data,
		.nr, .nc, .kr, .kc, .vmode, .wr_en, .cmd, .sts, .sum
	);

	c2d_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_KERNEL(MAX_KERNEL),
		.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk, .arst_n, .in_beat(in_data), .wr_en, .cmd,
		.nr, .nc, .kr, .kc, .vmode, .sts, .sum
	);
endmodule
`default_nettype wire
